// ===== rtl/core/and_inverter_truth_table_eval_core_macros.svh =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: assertion macros
// Shared concurrent assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef AND_INVERTER_TRUTH_TABLE_EVAL_CORE_MACROS_SVH
`define AND_INVERTER_TRUTH_TABLE_EVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AIGTT_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AIGTT_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/aigtt_pkg.sv =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: package
// Widths, codes, elementary tables and the transaction types passed between
// the front end, the op queue and the execution back end.
// ----------------------------------------------------------------------------
`default_nettype none

package aigtt_pkg;

    localparam int MAX_GATES_DEF = 32;
    localparam int LIT_W         = 7;
    localparam int NODE_W        = 6;
    localparam int NV_W          = 3;
    localparam int ELEM_W        = 3;
    localparam int TT_W          = 64;
    localparam int CFG_IDX_W     = 1;
    localparam int QUEUE_DEPTH   = 4;

    // Command codes
    localparam logic CMD_GATE   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VARS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 1'd1;

    // Legal input counts and reset value
    localparam logic [NV_W-1:0] NV_MIN       = 3'd1;
    localparam logic [NV_W-1:0] NV_MAX       = 3'd6;
    localparam logic [NV_W-1:0] NUM_VARS_RST = 3'd6;

    typedef logic [TT_W-1:0] tt_t;

    // One resolved operand
    typedef struct packed {
        logic              is_elem;
        logic [ELEM_W-1:0] elem_idx;
        logic [NODE_W-1:0] gate_idx;
        logic              inv;
    } aigtt_opnd_t;

    // One queued operation: a gate to store, or a finish
    typedef struct packed {
        logic        is_fin;
        logic        fin_ok;
        logic [NV_W-1:0] nv;
        aigtt_opnd_t opa;
        aigtt_opnd_t opb;
    } aigtt_op_t;

    // Elementary variable tables
    function automatic tt_t elem_tt(input logic [ELEM_W-1:0] idx);
        tt_t v;
        unique case (idx)
            3'd1:    v = 64'hCCCC_CCCC_CCCC_CCCC;
            3'd2:    v = 64'hF0F0_F0F0_F0F0_F0F0;
            3'd3:    v = 64'hFF00_FF00_FF00_FF00;
            3'd4:    v = 64'hFFFF_0000_FFFF_0000;
            3'd5:    v = 64'hFFFF_FFFF_0000_0000;
            default: v = 64'hAAAA_AAAA_AAAA_AAAA;
        endcase
        return v;
    endfunction

    // Valid rows of a table for the given input count
    function automatic tt_t table_mask(input logic [NV_W-1:0] nv);
        tt_t m;
        unique case (nv)
            3'd0:    m = 64'h0000_0000_0000_0001;
            3'd1:    m = 64'h0000_0000_0000_0003;
            3'd2:    m = 64'h0000_0000_0000_000F;
            3'd3:    m = 64'h0000_0000_0000_00FF;
            3'd4:    m = 64'h0000_0000_0000_FFFF;
            3'd5:    m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/and_inverter_truth_table_eval_core.sv =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: top level
// Evaluates a stream of AND gates over up to six inputs as 64-bit tables.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one transaction per gate (cmd gate,
//   lit_a, lit_b) or per finish (cmd finish, out_lit). A transaction is taken
//   at a clock edge with in_valid high and in_stall low.
//   Output channel (out_valid / out_stall): one result per finish, giving the
//   masked table, valid_res and matches_res. Gates give no result.
//   Config port: cfg_we writes cfg_data to register cfg_index (num_vars,
//   target_truth) at the clock edge; write only while the block is idle.
// Timing:
//   One transaction per cycle sustained while in_stall is low. A finish result
//   passes through the queue, the store read registers and the output register.
//   The store has one write and two read ports; the newest gate table is
//   forwarded so that each gate may use the previous one at full rate.
//   A stalled result holds; the four-entry op queue keeps taking input
//   until it fills, then in_stall rises.
// Reset: empties queue and pipeline, clears program state, num_vars = 6,
//   target_truth = 0.
// ----------------------------------------------------------------------------
`default_nettype none

module and_inverter_truth_table_eval_core #(
    parameter int MAX_GATES = aigtt_pkg::MAX_GATES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [aigtt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [aigtt_pkg::TT_W-1:0]        cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              cmd,
    input  wire logic [aigtt_pkg::LIT_W-1:0]       lit_a,
    input  wire logic [aigtt_pkg::LIT_W-1:0]       lit_b,
    input  wire logic [aigtt_pkg::LIT_W-1:0]       out_lit,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [aigtt_pkg::TT_W-1:0]             truth,
    output logic                                   valid_res,
    output logic                                   matches_res
);
    import aigtt_pkg::*;

    logic [NV_W-1:0] num_vars_reg;
    tt_t             target_reg;
    logic            q_full, q_empty, q_push, q_pop;
    aigtt_op_t       q_in, q_out;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_vars_reg <= NUM_VARS_RST;
            target_reg   <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_NUM_VARS: num_vars_reg <= cfg_data[NV_W-1:0];
                CFG_TARGET:   target_reg   <= cfg_data;
            endcase
        end
    end

    // Front end: accept and classify
    aigtt_front #(
        .MAX_GATES (MAX_GATES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .lit_a    (lit_a),
        .lit_b    (lit_b),
        .out_lit  (out_lit),
        .num_vars (num_vars_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    // Op queue
    aigtt_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_data  (q_out)
    );

    // Back end: store access, gate evaluation, result
    aigtt_back #(
        .MAX_GATES (MAX_GATES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .target_truth (target_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .truth        (truth),
        .valid_res    (valid_res),
        .matches_res  (matches_res)
    );

endmodule

`default_nettype wire

// ===== rtl/core/aigtt_queue.sv =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: op queue
// Short register FIFO between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module aigtt_queue (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    input  aigtt_pkg::aigtt_op_t      push_data,
    output logic                      full,
    input  wire logic                 pop,
    output logic                      empty,
    output aigtt_pkg::aigtt_op_t      pop_data
);
    import aigtt_pkg::*;

    localparam int QAW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QAW-1:0] PTR_LAST = QAW'(QUEUE_DEPTH - 1);
    localparam logic [QCW-1:0] CNT_FULL = QCW'(QUEUE_DEPTH);

    aigtt_op_t      entry_reg [QUEUE_DEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    // Status and read side
    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QAW'(1);
        end
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCW'(1);
            2'b01:   count_next = count_reg - QCW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aigtt_front.sv =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: front end
// Accepts input transactions, checks references against the current program
// size, tracks the sticky error, and queues gates and finishes for execution.
// ----------------------------------------------------------------------------
`default_nettype none

module aigtt_front #(
    parameter int MAX_GATES = aigtt_pkg::MAX_GATES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          cmd,
    input  wire logic [aigtt_pkg::LIT_W-1:0]   lit_a,
    input  wire logic [aigtt_pkg::LIT_W-1:0]   lit_b,
    input  wire logic [aigtt_pkg::LIT_W-1:0]   out_lit,
    input  wire logic [aigtt_pkg::NV_W-1:0]    num_vars,
    input  wire logic                          q_full,
    output logic                               q_push,
    output aigtt_pkg::aigtt_op_t               q_data
);
    import aigtt_pkg::*;

    localparam int GCW  = $clog2(MAX_GATES + 1);
    localparam int CMPW = ((GCW > NODE_W) ? GCW : NODE_W) + 1;
    localparam logic [GCW-1:0] GC_MAX = GCW'(MAX_GATES);

    logic [GCW-1:0]  gate_count_reg, gate_count_next;
    logic            bad_reg, bad_next;
    logic            accept;
    logic            nv_ok;
    logic            gc_full;
    logic            ok_a, ok_b, ok_o;
    logic [CMPW-1:0] limit;
    aigtt_opnd_t     opnd_a, opnd_b, opnd_o;

    // Split a literal into elementary or stored operand
    function automatic aigtt_opnd_t lit_opnd(input logic [LIT_W-1:0] lit,
                                             input logic [NV_W-1:0]  nv);
        aigtt_opnd_t       o;
        logic [NODE_W-1:0] node;
        node       = lit[LIT_W-1:1];
        o.is_elem  = (node < NODE_W'(nv));
        o.elem_idx = node[ELEM_W-1:0];
        o.gate_idx = node - NODE_W'(nv);
        o.inv      = lit[0];
        return o;
    endfunction

    // Node must lie below inputs plus gates stored so far
    function automatic logic lit_ok(input logic [LIT_W-1:0] lit,
                                    input logic [CMPW-1:0]  lim);
        return CMPW'(lit[LIT_W-1:1]) < lim;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // Classification
    always_comb
    begin
        limit   = CMPW'(num_vars) + CMPW'(gate_count_reg);
        nv_ok   = (num_vars >= NV_MIN) && (num_vars <= NV_MAX);
        gc_full = (gate_count_reg >= GC_MAX);
        opnd_a  = lit_opnd(lit_a, num_vars);
        opnd_b  = lit_opnd(lit_b, num_vars);
        opnd_o  = lit_opnd(out_lit, num_vars);
        ok_a    = lit_ok(lit_a, limit);
        ok_b    = lit_ok(lit_b, limit);
        ok_o    = lit_ok(out_lit, limit);

        q_data.is_fin = (cmd == CMD_FINISH);
        q_data.fin_ok = !bad_reg && nv_ok && ok_o;
        q_data.nv     = num_vars;
        q_data.opa    = (cmd == CMD_FINISH) ? opnd_o : opnd_a;
        q_data.opb    = opnd_b;
    end

    // Program bookkeeping: gates with an error are dropped here
    always_comb
    begin
        q_push          = 1'b0;
        gate_count_next = gate_count_reg;
        bad_next        = bad_reg;
        if (accept)
        begin
            if (cmd == CMD_FINISH)
            begin
                q_push          = 1'b1;
                gate_count_next = '0;
                bad_next        = 1'b0;
            end
            else if (!bad_reg)
            begin
                if (!nv_ok || gc_full || !ok_a || !ok_b)
                begin
                    bad_next = 1'b1;
                end
                else
                begin
                    q_push          = 1'b1;
                    gate_count_next = gate_count_reg + GCW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_count_reg <= '0;
            bad_reg        <= 1'b0;
        end
        else
        begin
            gate_count_reg <= gate_count_next;
            bad_reg        <= bad_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/aigtt_back.sv =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: back end
// Two-stage execution: read the gate table store, then AND the operands and
// write the next slot, or form the finish result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module aigtt_back #(
    parameter int MAX_GATES = aigtt_pkg::MAX_GATES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         q_empty,
    input  aigtt_pkg::aigtt_op_t              q_data,
    output logic                              q_pop,
    input  wire logic [aigtt_pkg::TT_W-1:0]   target_truth,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [aigtt_pkg::TT_W-1:0]        truth,
    output logic                              valid_res,
    output logic                              matches_res
);
    import aigtt_pkg::*;

    localparam int AW = (MAX_GATES > 1) ? $clog2(MAX_GATES) : 1;

    // Gate table store
    tt_t            mem [MAX_GATES];

    logic           s2_valid_reg;
    aigtt_op_t      s2_op_reg;
    tt_t            rd_a_reg, rd_b_reg;
    logic           byp_a_reg, byp_b_reg;
    tt_t            byp_val_reg;
    logic [AW-1:0]  wr_ptr_reg;
    logic           out_valid_reg;
    tt_t            truth_reg;
    logic           valid_res_reg;
    logic           matches_reg;

    logic           adv;
    logic           issue;
    logic           s2_write;
    logic           load_out;
    logic [AW-1:0]  ra, rb;
    tt_t            a_val, b_val, and_val;
    tt_t            mask, t_masked;

    // Operand value: elementary, forwarded, or read from the store
    function automatic tt_t opnd_val(input aigtt_opnd_t o, input tt_t rd,
                                     input logic byp, input tt_t byp_v);
        tt_t v;
        v = o.is_elem ? elem_tt(o.elem_idx) : (byp ? byp_v : rd);
        return o.inv ? ~v : v;
    endfunction

    // Pipeline control: only a finish blocked by a full output stalls
    assign load_out = s2_valid_reg && s2_op_reg.is_fin && adv;
    assign s2_write = s2_valid_reg && !s2_op_reg.is_fin;
    assign adv      = !(s2_valid_reg && s2_op_reg.is_fin && out_valid_reg && out_stall);
    assign issue    = adv && !q_empty;
    assign q_pop    = issue;
    assign ra       = AW'(q_data.opa.gate_idx);
    assign rb       = AW'(q_data.opb.gate_idx);

    // Stage 2 datapath
    always_comb
    begin
        a_val    = opnd_val(s2_op_reg.opa, rd_a_reg, byp_a_reg, byp_val_reg);
        b_val    = opnd_val(s2_op_reg.opb, rd_b_reg, byp_b_reg, byp_val_reg);
        and_val  = a_val & b_val;
        mask     = table_mask(s2_op_reg.nv);
        t_masked = a_val & mask;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            wr_ptr_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s2_valid_reg <= issue;
            end
            if (s2_write)
            begin
                wr_ptr_reg <= wr_ptr_reg + AW'(1);
            end
            else if (load_out)
            begin
                wr_ptr_reg <= '0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 reads, with forwarding of the table written in the same cycle
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s2_op_reg   <= q_data;
            rd_a_reg    <= mem[ra];
            rd_b_reg    <= mem[rb];
            byp_a_reg   <= s2_write && (ra == wr_ptr_reg);
            byp_b_reg   <= s2_write && (rb == wr_ptr_reg);
            byp_val_reg <= and_val;
        end
        if (s2_write)
        begin
            mem[wr_ptr_reg] <= and_val;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            truth_reg     <= s2_op_reg.fin_ok ? t_masked : '0;
            valid_res_reg <= s2_op_reg.fin_ok;
            matches_reg   <= s2_op_reg.fin_ok && (t_masked == (target_truth & mask));
        end
    end

    assign out_valid   = out_valid_reg;
    assign truth       = truth_reg;
    assign valid_res   = valid_res_reg;
    assign matches_res = matches_reg;

endmodule

`default_nettype wire

// ===== rtl/core/aigtt_checker.sv =====
// ----------------------------------------------------------------------------
// And-inverter truth table evaluator: port checker
// Watches the top-level result channel and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "and_inverter_truth_table_eval_core_macros.svh"

module aigtt_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             out_valid,
    input wire logic                             out_stall,
    input wire logic [aigtt_pkg::TT_W-1:0]       truth,
    input wire logic                             valid_res,
    input wire logic                             matches_res
);

    // A stalled result transaction stays put
    `AIGTT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(truth) && $stable(valid_res) && $stable(matches_res), "stalled result changed")

    // Invalid programs report an all-zero result
    `AIGTT_ASSERT_SAME(a_invalid_zero, clk, rst_n, out_valid && !valid_res, (truth == '0) && !matches_res, "invalid result not zero")

    // A match is only reported for a valid program
    `AIGTT_ASSERT_SAME(a_match_valid, clk, rst_n, out_valid && matches_res, valid_res, "match without valid program")

endmodule

bind and_inverter_truth_table_eval_core aigtt_checker u_aigtt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .truth       (truth),
    .valid_res   (valid_res),
    .matches_res (matches_res)
);

`default_nettype wire
